// ----- hw/rtl/vnra_pkg.sv -----
// Package for the running-average vertex normal block.
// Holds widths, fixed-point constants and shared control types. No dependencies.
`default_nettype none
package vnra_pkg;
    localparam int VERTEX_COUNT_DEF = 4096;
    localparam int COORD_WIDTH_DEF  = 16;
    localparam int INDEX_WIDTH      = 12;
    localparam int NORMAL_WIDTH     = 16;
    localparam int COUNT_WIDTH      = 16;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [14:0] ONE_Q14   = 15'd16384;
    localparam int MAG_WIDTH        = 66;
    localparam int SQ_WIDTH         = 62;
    localparam int ROOT_WIDTH       = 31;

    typedef struct packed {
        logic start;
        logic busy;
    } vnra_ctl_t;
endpackage
`default_nettype wire

// ----- hw/rtl/vnra_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module vnra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/vnra_norm.sv -----
// Iterative normalizer: shift to range, square sum, bit-serial root, serial divides.
// Depends on vnra_pkg.
`default_nettype none
module vnra_norm
    import vnra_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [MAG_WIDTH-1:0]  mag_in [3],
    input  wire logic [2:0]            neg_in,
    output logic                       done,
    output logic signed [NORMAL_WIDTH-1:0] res [3]
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_SQ = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_DIV = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg;
    logic [MAG_WIDTH-1:0] mag_reg [3];
    logic [2:0] neg_reg;
    logic [SQ_WIDTH-1:0] sum_reg;
    logic [SQ_WIDTH-1:0] rem_reg;
    logic [ROOT_WIDTH-1:0] root_reg;
    logic [5:0] cnt_reg;
    logic [1:0] comp_reg;
    logic [45:0] dvd_reg;
    logic [ROOT_WIDTH:0] drem_reg;
    logic [15:0] quo_reg;
    logic [MAG_WIDTH-1:0] maxm;
    logic [29:0] sqa;
    logic [59:0] sq;
    logic [ROOT_WIDTH+1:0] trial;
    logic [SQ_WIDTH-1:0] rem_sh;
    logic [ROOT_WIDTH:0] drem_sh;
    logic [15:0] q_rnd;

    always_comb
    begin
        maxm = mag_reg[0];
        if (mag_reg[1] > maxm) maxm = mag_reg[1];
        if (mag_reg[2] > maxm) maxm = mag_reg[2];
        sqa = mag_reg[comp_reg][29:0];
        sq = sqa * sqa;
        rem_sh = {rem_reg[SQ_WIDTH-3:0], sum_reg[SQ_WIDTH-1:SQ_WIDTH-2]};
        trial = {root_reg, 2'b01};
        drem_sh = {drem_reg[ROOT_WIDTH-1:0], dvd_reg[45]};
        q_rnd = (quo_reg > 16'(ONE_Q14)) ? 16'(ONE_Q14) : quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        mag_reg <= mag_in;
                        neg_reg <= neg_in;
                        state_reg <= S_SHIFT;
                    end
                end
                S_SHIFT:
                begin
                    if (maxm == '0)
                    begin
                        res[0] <= '0; res[1] <= '0; res[2] <= '0;
                        state_reg <= S_DONE;
                    end
                    else if (maxm >= (MAG_WIDTH'(1) << 30))
                    begin
                        for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                    end
                    else if (maxm < (MAG_WIDTH'(1) << 29))
                    begin
                        for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                    end
                    else
                    begin
                        sum_reg <= '0;
                        comp_reg <= 2'd0;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    sum_reg <= sum_reg + SQ_WIDTH'(sq);
                    if (comp_reg == 2'd2)
                    begin
                        rem_reg <= '0;
                        root_reg <= '0;
                        cnt_reg <= 6'd0;
                        state_reg <= S_ROOT;
                    end
                    else
                    begin
                        comp_reg <= comp_reg + 2'd1;
                    end
                end
                S_ROOT:
                begin
                    sum_reg <= sum_reg << 2;
                    if (rem_sh >= SQ_WIDTH'(trial))
                    begin
                        rem_reg <= rem_sh - SQ_WIDTH'(trial);
                        root_reg <= {root_reg[ROOT_WIDTH-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        root_reg <= {root_reg[ROOT_WIDTH-2:0], 1'b0};
                    end
                    if (cnt_reg == 6'd30)
                    begin
                        comp_reg <= 2'd0;
                        cnt_reg <= 6'd0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_DIV:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        dvd_reg <= {2'd0, mag_reg[comp_reg][29:0], 14'd0}
                            + 46'(root_reg[ROOT_WIDTH-1:1]);
                        drem_reg <= '0;
                        quo_reg <= '0;
                        cnt_reg <= 6'd1;
                    end
                    else if (cnt_reg <= 6'd46)
                    begin
                        dvd_reg <= dvd_reg << 1;
                        if (drem_sh >= {1'b0, root_reg})
                        begin
                            drem_reg <= drem_sh - {1'b0, root_reg};
                            quo_reg <= {quo_reg[14:0], 1'b1};
                        end
                        else
                        begin
                            drem_reg <= drem_sh;
                            quo_reg <= {quo_reg[14:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                    else
                    begin
                        res[comp_reg] <= neg_reg[comp_reg] ? -$signed(q_rnd)
                                                           : $signed(q_rnd);
                        cnt_reg <= 6'd0;
                        if (comp_reg == 2'd2)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            comp_reg <= comp_reg + 2'd1;
                        end
                    end
                end
                S_DONE:
                begin
                    done <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_DONE)
        else $error("normalizer done out of sequence");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SQ |-> comp_reg <= 2'd2)
        else $error("component index out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROOT |-> cnt_reg <= 6'd30)
        else $error("root iteration overrun");
endmodule
`default_nettype wire

// ----- hw/rtl/vertex_normal_running_average.sv -----
// Top level of the running-average vertex normal block.
// Depends on vnra_pkg, vnra_ram and vnra_norm.
//
// channel | dir | fields
// s_axis  | in  | tdata: index_a,b,c, pos_a_xyz, pos_b_xyz, pos_c_xyz
// m_axis  | out | tdata: vertex_index, normal_xyz, seen_total; tlast: last_of_triangle
//
// A triangle runs the shared normalizer once for the face and once per repeat sighting,
// four passes at most. Each pass does a range shift, a 31-step root and three divides.
// After reset a clearing pass zeroes the counts; no item is accepted meanwhile.
// Output stalls hold the sequencer at the result register.
`default_nettype none
module vertex_normal_running_average
    import vnra_pkg::*;
#(
    parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // index_a, index_b, index_c, pos_a_x..z, pos_b_x..z, pos_c_x..z
    input  wire logic [183:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // vertex_index, normal_x, normal_y, normal_z, seen_total (zero fill)
    output logic [79:0]       m_axis_tdata,
    // last_of_triangle
    output logic              m_axis_tlast
);
    localparam int AW = $clog2(VERTEX_COUNT);

    localparam logic [3:0] T_CLEAR = 4'd0;
    localparam logic [3:0] T_IDLE = 4'd1;
    localparam logic [3:0] T_CROSS = 4'd2;
    localparam logic [3:0] T_FACE = 4'd3;
    localparam logic [3:0] T_RD = 4'd4;
    localparam logic [3:0] T_RDW = 4'd5;
    localparam logic [3:0] T_MUL = 4'd6;
    localparam logic [3:0] T_BLEND = 4'd7;
    localparam logic [3:0] T_WR = 4'd8;
    localparam logic [3:0] T_OUT = 4'd9;

    logic [3:0] state_reg;
    logic [AW-1:0] clr_reg;
    logic [1:0] k_reg;
    logic [1:0] ci_reg;
    logic [INDEX_WIDTH-1:0] idx_reg [3];
    logic signed [16:0] d_reg [6];
    logic signed [34:0] cr_reg [3];
    logic signed [NORMAL_WIDTH-1:0] face_reg [3];
    logic signed [NORMAL_WIDTH-1:0] nv_reg [3];
    logic signed [NORMAL_WIDTH-1:0] old_reg [3];
    logic signed [33:0] acc_reg [3];
    logic [COUNT_WIDTH-1:0] n_reg;
    logic in_range;
    logic [AW-1:0] addr;
    logic cnt_we, nrm_we;
    logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;
    logic [47:0] nrm_rdata;
    logic norm_start, norm_done;
    logic [MAG_WIDTH-1:0] nmag [3];
    logic [2:0] nneg;
    logic signed [NORMAL_WIDTH-1:0] nres [3];
    logic blend_mode;
    logic signed [33:0] pa, pb;
    logic signed [32:0] blend_prod;
    logic signed [16:0] ma, mb, mc, md;
    logic [COUNT_WIDTH-1:0] n_inc;
    vnra_ctl_t ctl;

    assign in_range = 32'(idx_reg[k_reg]) < VERTEX_COUNT;
    assign addr = (state_reg == T_CLEAR) ? clr_reg : AW'(idx_reg[k_reg]);
    assign cnt_we = (state_reg == T_CLEAR) || (state_reg == T_WR && in_range);
    assign nrm_we = state_reg == T_WR && in_range;
    assign cnt_wdata = (state_reg == T_CLEAR) ? '0 : n_reg;
    assign n_inc = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + 16'd1;
    assign ctl.start = norm_start;
    assign ctl.busy = state_reg == T_FACE || state_reg == T_BLEND;

    always_comb
    begin
        unique case (ci_reg)
            2'd0: begin ma = d_reg[1]; mb = d_reg[5]; mc = d_reg[2]; md = d_reg[4]; end
            2'd1: begin ma = d_reg[2]; mb = d_reg[3]; mc = d_reg[0]; md = d_reg[5]; end
            default: begin ma = d_reg[0]; mb = d_reg[4]; mc = d_reg[1]; md = d_reg[3]; end
        endcase
        pa = ma * mb;
        pb = mc * md;
        blend_prod = old_reg[ci_reg] * $signed({1'b0, n_reg - 16'd1});
        for (int i = 0; i < 3; i++)
        begin
            if (blend_mode)
            begin
                nneg[i] = acc_reg[i][33];
                nmag[i] = MAG_WIDTH'(acc_reg[i][33] ? -acc_reg[i] : acc_reg[i]);
            end
            else
            begin
                nneg[i] = cr_reg[i][34];
                nmag[i] = MAG_WIDTH'(cr_reg[i][34] ? -cr_reg[i] : cr_reg[i]);
            end
        end
    end

    assign blend_mode = state_reg == T_BLEND;

    vnra_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(VERTEX_COUNT)) u_count (
        .clk(clk), .we(cnt_we), .addr(addr), .wdata(cnt_wdata), .rdata(cnt_rdata));
    vnra_ram #(.WIDTH(48), .DEPTH(VERTEX_COUNT)) u_normal (
        .clk(clk), .we(nrm_we), .addr(addr),
        .wdata({nv_reg[2], nv_reg[1], nv_reg[0]}), .rdata(nrm_rdata));
    vnra_norm u_norm (
        .clk(clk), .rst_n(rst_n), .start(ctl.start), .mag_in(nmag), .neg_in(nneg),
        .done(norm_done), .res(nres));

    assign s_axis_tready = state_reg == T_IDLE;
    assign m_axis_tvalid = state_reg == T_OUT;
    assign m_axis_tlast = k_reg == 2'd2;
    assign m_axis_tdata = {4'd0, (in_range ? n_reg : 16'd0), nv_reg[2], nv_reg[1],
                           nv_reg[0], idx_reg[k_reg]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_CLEAR;
            clr_reg <= '0;
            norm_start <= 1'b0;
            k_reg <= '0;
        end
        else
        begin
            norm_start <= 1'b0;
            unique case (state_reg)
                T_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(VERTEX_COUNT - 1)) state_reg <= T_IDLE;
                end
                T_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            idx_reg[i] <= s_axis_tdata[12*i +: 12];
                            d_reg[i] <= 17'(signed'(s_axis_tdata[84+16*i +: 16]))
                                      - 17'(signed'(s_axis_tdata[36+16*i +: 16]));
                            d_reg[3+i] <= 17'(signed'(s_axis_tdata[132+16*i +: 16]))
                                        - 17'(signed'(s_axis_tdata[36+16*i +: 16]));
                        end
                        ci_reg <= '0;
                        k_reg <= '0;
                        state_reg <= T_CROSS;
                    end
                end
                T_CROSS:
                begin
                    cr_reg[ci_reg] <= 35'(pa) - 35'(pb);
                    if (ci_reg == 2'd2)
                    begin
                        norm_start <= 1'b1;
                        state_reg <= T_FACE;
                    end
                    else ci_reg <= ci_reg + 2'd1;
                end
                T_FACE:
                begin
                    if (norm_done)
                    begin
                        face_reg <= nres;
                        state_reg <= T_RD;
                    end
                end
                T_RD: state_reg <= T_RDW;
                T_RDW:
                begin
                    old_reg[0] <= nrm_rdata[15:0];
                    old_reg[1] <= nrm_rdata[31:16];
                    old_reg[2] <= nrm_rdata[47:32];
                    n_reg <= n_inc;
                    ci_reg <= '0;
                    if (!in_range || n_inc == 16'd1)
                    begin
                        nv_reg <= face_reg;
                        state_reg <= T_WR;
                    end
                    else state_reg <= T_MUL;
                end
                T_MUL:
                begin
                    acc_reg[ci_reg] <= 34'(blend_prod) + 34'(face_reg[ci_reg]);
                    if (ci_reg == 2'd2)
                    begin
                        norm_start <= 1'b1;
                        state_reg <= T_BLEND;
                    end
                    else ci_reg <= ci_reg + 2'd1;
                end
                T_BLEND:
                begin
                    if (norm_done)
                    begin
                        nv_reg <= nres;
                        state_reg <= T_WR;
                    end
                end
                T_WR: state_reg <= T_OUT;
                T_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        if (k_reg == 2'd2) state_reg <= T_IDLE;
                        else
                        begin
                            k_reg <= k_reg + 2'd1;
                            state_reg <= T_RD;
                        end
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        nrm_we |-> n_reg != 16'd0)
        else $error("normal written with zero count");
    assert property (@(posedge clk) disable iff (!rst_n)
        norm_done |-> ctl.busy)
        else $error("normalizer finished outside a wait state");
endmodule
`default_nettype wire

// ----- test/vertex_normal_running_average_test.sv -----
// Testbench for vertex_normal_running_average: streams triangles, predicts per-vertex
// running-average normals and checks every result item field by field.
// Depends on vnra_pkg and the block's RTL only.
module vertex_normal_running_average_test
    import vnra_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  VCOUNT       = 4096;
    localparam int  CYCLE_LIMIT  = 2000000;
    localparam int  DRAIN_CYCLES = 1100;
    localparam int  RANDOM_ITEMS = 230;

    typedef logic signed [NORMAL_WIDTH-1:0] q14_t;

    typedef struct {
        q14_t x;
        q14_t y;
        q14_t z;
    } normal_t;

    typedef struct {
        logic [INDEX_WIDTH-1:0] vidx;
        normal_t                nrm;
        logic [COUNT_WIDTH-1:0] seen;
        logic                   last;
    } vertex_update_t;

    typedef struct {
        int idx[3];
        int pos[9];
        bit typed;
        int nx;
        int ny;
        int nz;
    } triangle_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [183:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [79:0]  m_axis_tdata;
    logic         m_axis_tlast;

    vertex_update_t pending_updates[$];
    int             sightings[VCOUNT];
    normal_t        stored_normals[VCOUNT];
    int             error_count;
    int             cycle_count;

    vertex_normal_running_average i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // index_a,b,c, pos_a_xyz, pos_b_xyz, pos_c_xyz
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // vertex_index, normal_x,y,z, seen_total
        .m_axis_tlast  (m_axis_tlast)    // last_of_triangle
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x  -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic normal_t unit_vector(input longint vx, input longint vy,
                                            input longint vz);
        longint          comp[3];
        longint unsigned mag[3];
        longint unsigned peak;
        longint unsigned sum;
        longint unsigned root;
        longint unsigned q;
        q14_t            res[3];
        normal_t         n;
        comp = '{vx, vy, vz};
        peak = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (comp[i] < 0) ? -comp[i] : comp[i];
            if (mag[i] > peak)
                peak = mag[i];
        end
        if (peak == 0)
        begin
            n.x = 0;
            n.y = 0;
            n.z = 0;
            return n;
        end
        while (peak >= (64'd1 << 30))
        begin
            peak >>= 1;
            for (int i = 0; i < 3; i++)
                mag[i] >>= 1;
        end
        while (peak < (64'd1 << 29))
        begin
            peak <<= 1;
            for (int i = 0; i < 3; i++)
                mag[i] <<= 1;
        end
        sum  = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        root = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = (mag[i] * 64'd16384 + root / 2) / root;
            if (q > 16384)
                q = 16384;
            res[i] = (comp[i] < 0) ? -q14_t'(q) : q14_t'(q);
        end
        n.x = res[0];
        n.y = res[1];
        n.z = res[2];
        return n;
    endfunction

    function automatic normal_t triangle_normal(input int pos[9]);
        longint d[6];
        for (int i = 0; i < 3; i++)
        begin
            d[i]     = longint'(pos[3 + i]) - longint'(pos[i]);
            d[3 + i] = longint'(pos[6 + i]) - longint'(pos[i]);
        end
        return unit_vector(d[1] * d[5] - d[2] * d[4],
                           d[2] * d[3] - d[0] * d[5],
                           d[0] * d[4] - d[1] * d[3]);
    endfunction

    task automatic predict_triangle(input triangle_row_t row);
        normal_t        face;
        normal_t        old;
        vertex_update_t upd;
        int             n;
        face = triangle_normal(row.pos);
        if (row.typed)
        begin
            face.x = q14_t'(row.nx);
            face.y = q14_t'(row.ny);
            face.z = q14_t'(row.nz);
        end
        for (int k = 0; k < 3; k++)
        begin
            n = sightings[row.idx[k]];
            if (n < 65535)
                n++;
            sightings[row.idx[k]] = n;
            if (n == 1)
                upd.nrm = face;
            else
            begin
                old     = stored_normals[row.idx[k]];
                upd.nrm = unit_vector(longint'(old.x) * (n - 1) + face.x,
                                      longint'(old.y) * (n - 1) + face.y,
                                      longint'(old.z) * (n - 1) + face.z);
            end
            stored_normals[row.idx[k]] = upd.nrm;
            upd.vidx = INDEX_WIDTH'(row.idx[k]);
            upd.seen = COUNT_WIDTH'(n);
            upd.last = (k == 2);
            pending_updates = {pending_updates, upd};
        end
    endtask

    function automatic logic [183:0] pack_triangle(input triangle_row_t row);
        logic [183:0] d;
        d = '0;
        for (int k = 0; k < 3; k++)
            d[k*12 +: 12] = 12'(row.idx[k]);
        for (int i = 0; i < 9; i++)
            d[36 + i*16 +: 16] = 16'(row.pos[i]);
        return d;
    endfunction

    task automatic send_triangle(input triangle_row_t row, input int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= pack_triangle(row);
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_triangle(row);
    endtask

    function automatic triangle_row_t random_triangle();
        triangle_row_t row;
        int            pick;
        pick = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++)
            row.idx[k] = (pick < 7) ? $urandom_range(0, 11) : $urandom_range(0, VCOUNT - 1);
        for (int i = 0; i < 9; i++)
        begin
            if (pick < 5)
                row.pos[i] = $urandom_range(0, 8191) - 4096;
            else
                row.pos[i] = $urandom_range(0, 65535) - 32768;
        end
        if ($urandom_range(0, 19) == 0)
            for (int i = 3; i < 9; i++)
                row.pos[i] = row.pos[i % 3];
        row.typed = 1'b0;
        row.nx    = 0;
        row.ny    = 0;
        row.nz    = 0;
        return row;
    endfunction

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_updates.size() == 0)
                report_mismatch($sformatf("unexpected item tdata=%h", m_axis_tdata));
            else
            begin
                vertex_update_t e;
                e = pending_updates.pop_front();
                if (m_axis_tdata[11:0] !== e.vidx)
                    report_mismatch($sformatf("vertex_index %0d, want %0d",
                                              m_axis_tdata[11:0], e.vidx));
                if (m_axis_tdata[27:12] !== e.nrm.x)
                    report_mismatch($sformatf("normal_x %0d, want %0d (vertex %0d)",
                                              $signed(m_axis_tdata[27:12]), e.nrm.x, e.vidx));
                if (m_axis_tdata[43:28] !== e.nrm.y)
                    report_mismatch($sformatf("normal_y %0d, want %0d (vertex %0d)",
                                              $signed(m_axis_tdata[43:28]), e.nrm.y, e.vidx));
                if (m_axis_tdata[59:44] !== e.nrm.z)
                    report_mismatch($sformatf("normal_z %0d, want %0d (vertex %0d)",
                                              $signed(m_axis_tdata[59:44]), e.nrm.z, e.vidx));
                if (m_axis_tdata[75:60] !== e.seen)
                    report_mismatch($sformatf("seen_total %0d, want %0d (vertex %0d)",
                                              m_axis_tdata[75:60], e.seen, e.vidx));
                if (m_axis_tdata[79:76] !== 4'b0)
                    report_mismatch("nonzero fill bits");
                if (m_axis_tlast !== e.last)
                    report_mismatch($sformatf("last_of_triangle %b, want %b",
                                              m_axis_tlast, e.last));
            end
        end
    end

    int stall_mode;
    int stall_phase;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (stall_phase == 0)
        begin
            stall_mode  = $urandom_range(0, 3);
            stall_phase = $urandom_range(16, 200);
        end
        else
            stall_phase--;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= stall_phase[0];
            2:       m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= (stall_phase % 40) < 8;
        endcase
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    triangle_row_t directed_rows[12] = '{
        '{'{0, 1, 2}, '{0, 0, 0, 4096, 0, 0, 0, 4096, 0}, 1'b1, 0, 0, 16384},
        '{'{10, 11, 12}, '{0, 0, 0, 0, 4096, 0, 0, 0, 4096}, 1'b1, 16384, 0, 0},
        '{'{4093, 4094, 4095}, '{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 0, 0, 0},
        '{'{0, 2, 1}, '{0, 0, 0, 0, 4096, 0, 4096, 0, 0}, 1'b0, 0, 0, 0},
        '{'{7, 7, 7}, '{100, -200, 300, 4000, 50, -60, -700, 3000, 900}, 1'b0, 0, 0, 0},
        '{'{7, 7, 7}, '{-5, 9, 1, 1200, -800, 20, 30, -40, 2500}, 1'b0, 0, 0, 0},
        '{'{20, 21, 22}, '{-32768, -32768, -32768, 32767, -32768, 32767,
                           32767, 32767, -32768}, 1'b0, 0, 0, 0},
        '{'{23, 24, 25}, '{32767, 32767, 32767, -32768, 32767, -32768,
                           -32768, -32768, 32767}, 1'b0, 0, 0, 0},
        '{'{20, 23, 4095}, '{1, 0, 0, 0, 1, 0, 0, 0, 1}, 1'b0, 0, 0, 0},
        '{'{4093, 30, 31}, '{5, 5, 5, 5, 5, 5, 6, 6, 6}, 1'b0, 0, 0, 0},
        '{'{0, 10, 4094}, '{-32768, 0, 32767, 32767, 0, -32768, 0, 32767, 0}, 1'b0, 0, 0, 0},
        '{'{2730, 1365, 0}, '{-1, -1, -1, 2, 3, 4, -7, 8, -9}, 1'b0, 0, 0, 0}
    };

    initial
    begin
        int burst_left;
        int gap;
        triangle_row_t row;
        error_count   = 0;
        cycle_count   = 0;
        stall_mode    = 0;
        stall_phase   = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        for (int i = 0; i < VCOUNT; i++)
            sightings[i] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_triangle(directed_rows[i], (i % 3 == 2) ? $urandom_range(1, 4) : 0);

        // hold off until every update has drained
        s_axis_tvalid <= 1'b0;
        while (pending_updates.size() != 0)
            @(posedge clk);

        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            gap = 0;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 10);
                gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
            end
            burst_left--;
            row = random_triangle();
            send_triangle(row, gap);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_updates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/vnra_pkg.sv
hw/rtl/vnra_ram.sv
hw/rtl/vnra_norm.sv
hw/rtl/vertex_normal_running_average.sv
test/vertex_normal_running_average_test.sv
